// File: rtl/core/mfcb_pkg.sv
`default_nettype none
package mfcb_pkg;

  // frame store geometry
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int MAX_RADIUS = 16;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int AW         = XW + YW;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;

  // field and register widths
  localparam int POS_W      = 7;
  localparam int PIX_W      = 32;
  localparam int COV_W      = 8;
  localparam int RADIUS_W   = 5;
  localparam int DIM_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 56;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // window and histogram sizes
  localparam int WIN_W   = $clog2(2 * MAX_RADIUS + 1);
  localparam int CNT_W   = $clog2((2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1) + 1);
  localparam int CHANS   = 4;
  localparam int BIN_W   = 8;
  localparam int BINS    = 256;
  localparam int DIM_MAX = (XW > YW) ? XW : YW;
  localparam int COORD_W = ((DIM_MAX > WIN_W) ? DIM_MAX : WIN_W) + 2;

  // commands from controller to datapath
  typedef struct packed {
    logic             load;
    logic             capture;
    logic             orig_issue;
    logic             win_issue;
    logic [WIN_W-1:0] ix;
    logic [WIN_W-1:0] iy;
    logic             clear_issue;
    logic             scan_start;
    logic             scan_issue;
    logic [BIN_W-1:0] bin;
    logic             push;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [WIN_W-1:0] win_max;
    logic             out_full;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/core/mfcb_ram.sv
`default_nettype none
module mfcb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/core/mfcb_ctrl.sv
`default_nettype none
module mfcb_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  input  wire logic            in_mode,
  output logic                 in_ready,
  input  wire mfcb_pkg::stat_t stat,
  output mfcb_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_ORIG, S_WIN, S_DRAIN, S_SCAN, S_SCAN_END, S_PUSH
  } state_t;

  state_t                       state;
  logic [mfcb_pkg::WIN_W-1:0]   ix;
  logic [mfcb_pkg::WIN_W-1:0]   iy;
  logic [mfcb_pkg::BIN_W-1:0]   bin;
  logic                         drain;
  logic                         accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  // command decode
  always_comb begin
    cmd             = '0;
    cmd.ix          = ix;
    cmd.iy          = iy;
    cmd.bin         = bin;
    cmd.load        = accept && !in_mode;
    cmd.capture     = accept && in_mode;
    cmd.orig_issue  = (state == S_ORIG);
    cmd.win_issue   = (state == S_WIN);
    cmd.clear_issue = (state == S_CLEAR);
    cmd.scan_start  = (state == S_DRAIN);
    cmd.scan_issue  = (state == S_SCAN);
    cmd.push        = (state == S_PUSH) && !stat.out_full;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ix    <= '0;
      iy    <= '0;
      bin   <= '0;
      drain <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          bin <= bin + 1'b1;
          if (bin == mfcb_pkg::BIN_W'(mfcb_pkg::BINS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (accept && in_mode) state <= S_ORIG;
        end
        S_ORIG: begin
          ix    <= '0;
          iy    <= '0;
          state <= S_WIN;
        end
        S_WIN: begin
          if (ix == stat.win_max) begin
            ix <= '0;
            if (iy == stat.win_max) begin
              drain <= 1'b0;
              state <= S_DRAIN;
            end else begin
              iy <= iy + 1'b1;
            end
          end else begin
            ix <= ix + 1'b1;
          end
        end
        S_DRAIN: begin
          drain <= 1'b1;
          bin   <= '0;
          if (drain) state <= S_SCAN;
        end
        S_SCAN: begin
          bin <= bin + 1'b1;
          if (bin == mfcb_pkg::BIN_W'(mfcb_pkg::BINS - 1)) state <= S_SCAN_END;
        end
        S_SCAN_END: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (!stat.out_full) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/mfcb_dp.sv
`default_nettype none
module mfcb_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [mfcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mfcb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic [mfcb_pkg::POS_W-1:0]          pos_x,
  input  wire logic [mfcb_pkg::POS_W-1:0]          pos_y,
  input  wire logic [mfcb_pkg::PIX_W-1:0]          pixel_in,
  input  wire logic [mfcb_pkg::COV_W-1:0]          coverage,
  input  wire mfcb_pkg::cmd_t                      cmd,
  output mfcb_pkg::stat_t                          stat,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [mfcb_pkg::PIX_W-1:0]               pixel_out
);

  localparam int XW = mfcb_pkg::XW;
  localparam int YW = mfcb_pkg::YW;
  localparam int AW = mfcb_pkg::AW;
  localparam int CW = mfcb_pkg::COORD_W;
  localparam int NW = mfcb_pkg::CNT_W;
  localparam int BW = mfcb_pkg::BIN_W;
  localparam int WW = mfcb_pkg::WIN_W;

  // per channel blend: o + (m - o) * cov / 255, truncated toward zero
  function automatic logic [7:0] blend_chan(input logic [7:0] o, input logic [7:0] m,
                                            input logic [7:0] cov);
    logic        neg;
    logic [7:0]  mag;
    logic [15:0] p;
    logic [16:0] s;
    logic [7:0]  q;
    neg = (m < o);
    mag = neg ? (o - m) : (m - o);
    p   = mag * cov;
    s   = 17'(p) + 17'(p >> 8) + 17'd1;
    q   = s[15:8];
    return neg ? (o - q) : (o + q);
  endfunction

  logic [mfcb_pkg::RADIUS_W-1:0] radius;
  logic [mfcb_pkg::DIM_W-1:0]    frame_width;
  logic [mfcb_pkg::DIM_W-1:0]    frame_height;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= mfcb_pkg::RADIUS_W'(1);
      frame_width  <= mfcb_pkg::DIM_W'(128);
      frame_height <= mfcb_pkg::DIM_W'(128);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfcb_pkg::CFG_RADIUS: radius       <= cfg_data[mfcb_pkg::RADIUS_W-1:0];
        mfcb_pkg::CFG_WIDTH:  frame_width  <= cfg_data;
        mfcb_pkg::CFG_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamped register values
  logic [WW-1:0] r_eff;
  logic [XW-1:0] w_last;
  logic [YW-1:0] h_last;
  logic [NW-1:0] half;
  logic [WW:0]   side;
  always_comb begin
    if (radius == '0) r_eff = WW'(1);
    else if (32'(radius) > mfcb_pkg::MAX_RADIUS) r_eff = WW'(mfcb_pkg::MAX_RADIUS);
    else r_eff = WW'(radius);
    if (frame_width == '0) w_last = '0;
    else if (32'(frame_width) > mfcb_pkg::MAX_WIDTH) w_last = XW'(mfcb_pkg::MAX_WIDTH - 1);
    else w_last = XW'(frame_width - 1'b1);
    if (frame_height == '0) h_last = '0;
    else if (32'(frame_height) > mfcb_pkg::MAX_HEIGHT) h_last = YW'(mfcb_pkg::MAX_HEIGHT - 1);
    else h_last = YW'(frame_height - 1'b1);
    side = (WW + 1)'({r_eff, 1'b1});
    half = NW'((32'(side) * 32'(side)) >> 1);
  end
  assign stat.win_max = WW'({r_eff, 1'b0});

  // captured request
  logic [XW-1:0]                 cx;
  logic [YW-1:0]                 cy;
  logic [mfcb_pkg::COV_W-1:0]    cov;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cx  <= (32'(pos_x) > 32'(w_last)) ? w_last : XW'(pos_x);
      cy  <= (32'(pos_y) > 32'(h_last)) ? h_last : YW'(pos_y);
      cov <= coverage;
    end
  end

  // window coordinates, clamped to the active frame
  logic signed [CW-1:0] sx;
  logic signed [CW-1:0] sy;
  logic [XW-1:0]        wx;
  logic [YW-1:0]        wy;
  always_comb begin
    sx = $signed(CW'(cx) - CW'(r_eff) + CW'(cmd.ix));
    sy = $signed(CW'(cy) - CW'(r_eff) + CW'(cmd.iy));
    if (sx < 0) wx = '0;
    else if (sx > $signed(CW'(w_last))) wx = w_last;
    else wx = sx[XW-1:0];
    if (sy < 0) wy = '0;
    else if (sy > $signed(CW'(h_last))) wy = h_last;
    else wy = sy[YW-1:0];
  end

  // frame store
  logic [AW-1:0]              f_raddr;
  logic [AW-1:0]              f_waddr;
  logic [mfcb_pkg::PIX_W-1:0] f_rdata;
  assign f_raddr = cmd.orig_issue ? {cy, cx} : {wy, wx};
  assign f_waddr = {YW'(pos_y), XW'(pos_x)};

  mfcb_ram #(.WIDTH(mfcb_pkg::PIX_W), .DEPTH(mfcb_pkg::DEPTH)) u_frame (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (f_waddr),
    .wdata (pixel_in),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // pipeline flags
  logic                       orig_pend;
  logic                       v1;
  logic                       v2;
  logic                       wr_v;
  logic                       scan_pend;
  logic [BW-1:0]              bin_d;
  logic [mfcb_pkg::PIX_W-1:0] orig;
  always_ff @(posedge clk) begin
    if (rst) begin
      orig_pend <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      wr_v      <= 1'b0;
      scan_pend <= 1'b0;
    end else begin
      orig_pend <= cmd.orig_issue;
      v1        <= cmd.win_issue;
      v2        <= v1;
      wr_v      <= v2;
      scan_pend <= cmd.scan_issue;
    end
  end
  always_ff @(posedge clk) begin
    bin_d <= cmd.bin;
    if (orig_pend) orig <= f_rdata;
  end

  // per channel histograms
  logic [7:0] med [mfcb_pkg::CHANS];
  for (genvar c = 0; c < mfcb_pkg::CHANS; c++) begin : g_chan
    logic [BW-1:0] h_raddr;
    logic [BW-1:0] h_waddr;
    logic [NW-1:0] h_wdata;
    logic [NW-1:0] h_rdata;
    logic          h_we;
    logic [BW-1:0] bin2;
    logic [BW-1:0] wr_bin;
    logic [NW-1:0] wr_val;
    logic [NW-1:0] cnt_inc;
    logic [NW-1:0] acc;
    logic [NW-1:0] acc_next;
    logic          found;

    assign h_raddr  = v1 ? f_rdata[8*c +: 8] : cmd.bin;
    // forward the count written in the previous cycle to the same bin
    assign cnt_inc  = ((wr_v && (wr_bin == bin2)) ? wr_val : h_rdata) + 1'b1;
    assign h_we     = v2 || cmd.clear_issue || cmd.scan_issue;
    assign h_waddr  = v2 ? bin2 : cmd.bin;
    assign h_wdata  = v2 ? cnt_inc : '0;
    assign acc_next = acc + h_rdata;

    mfcb_ram #(.WIDTH(NW), .DEPTH(mfcb_pkg::BINS)) u_hist (
      .clk   (clk),
      .we    (h_we),
      .waddr (h_waddr),
      .wdata (h_wdata),
      .raddr (h_raddr),
      .rdata (h_rdata)
    );

    // count update and cumulative scan
    always_ff @(posedge clk) begin
      bin2   <= f_rdata[8*c +: 8];
      wr_bin <= bin2;
      wr_val <= cnt_inc;
      if (cmd.scan_start) begin
        acc    <= '0;
        found  <= 1'b0;
        med[c] <= 8'hFF;
      end else if (scan_pend) begin
        acc <= acc_next;
        if (!found && (acc_next > half)) begin
          found  <= 1'b1;
          med[c] <= bin_d;
        end
      end
    end
  end

  // blended result
  logic [mfcb_pkg::PIX_W-1:0] blended;
  always_comb begin
    for (int c = 0; c < mfcb_pkg::CHANS; c++) begin
      blended[8*c +: 8] = blend_chan(orig[8*c +: 8], med[c], cov);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.push) pixel_out <= blended;
  end
  assign stat.out_full = out_valid && !out_ready;

endmodule
`default_nettype wire

// File: rtl/core/median_filter_coverage_blend_top.sv
`default_nettype none
// channel   direction  contents
// s_axis    in         tuser: mode; tdata: pos_x, pos_y, pixel_in, coverage
// m_axis    out        tdata: pixel_out
// cfg       in         register write: radius, frame_width, frame_height
//
// a load request gives no result.
// a compute request does one frame read per window pixel into four histogram
// memories, then a 256-bin scan that also clears them.
// after reset a pass over all 256 bins clears the histograms before requests are taken.
// a finished result waits in the output register; new requests are taken meanwhile.
module median_filter_coverage_blend_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pos_x[6:0], pos_y[13:7], pixel_in[45:14], coverage[53:46], zero pad
  input  wire logic [mfcb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // mode[0]
  input  wire logic                                s_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // pixel_out[31:0]
  output logic [mfcb_pkg::PIX_W-1:0]               m_axis_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [mfcb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mfcb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mfcb_pkg::cmd_t  cmd;
  mfcb_pkg::stat_t stat;

  // controller
  mfcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_mode  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath
  mfcb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pos_x     (s_axis_tdata[6:0]),
    .pos_y     (s_axis_tdata[13:7]),
    .pixel_in  (s_axis_tdata[45:14]),
    .coverage  (s_axis_tdata[53:46]),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .pixel_out (m_axis_tdata)
  );

endmodule
`default_nettype wire
